// ----- rtl/sgps_pkg.sv -----
// sgps_pkg: shared widths, register indexes, reset values and helpers
// for the spiral growth point step pipeline; no dependencies
package sgps_pkg;

   // default coordinate width and fixed field widths
   localparam int COORD_WIDTH_DEF = 32;
   localparam int ROT_COEF_W      = 18;
   localparam int STEP_W          = 24;
   localparam int PARAM_W         = 32;
   localparam int CSR_IDX_W       = 2;

   // internal datapath widths
   localparam int SCALE_W = 31;   // prescaled magnitude bits
   localparam int PROD_W  = 50;   // 18 x 32 signed product
   localparam int ROT_W   = 51;   // rotated component, signed
   localparam int MAG_W   = 50;   // rotated magnitude
   localparam int NORM_W  = 30;   // normalized magnitude in [2^29, 2^30)
   localparam int SQ_W    = 60;   // squared normalized magnitude
   localparam int RAD_W   = 62;   // sum of squares, even width for the root
   localparam int ROOT_W  = 31;   // root bits, one per pipeline stage
   localparam int REM_W   = 33;   // root remainder
   localparam int NUM_W   = 55;   // step * magnitude plus rounding term
   localparam int QUO_W   = 25;   // quotient bits, one per pipeline stage
   localparam int NORM_TOP = 29;  // target position of the leading one
   localparam int SCALE_TOP = 30; // highest bit a prescaled magnitude may use

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LEN = 2'd2;

   // reset values of the configuration registers
   localparam logic signed [ROT_COEF_W-1:0] ROT_COS_RST = 18'sd10252;
   localparam logic signed [ROT_COEF_W-1:0] ROT_SIN_RST = -18'sd64729;
   localparam logic [STEP_W-1:0]            STEP_RST    = 24'd6554;

   // result tuser bit positions
   localparam int USER_DEG = 0;
   localparam int USER_SAT = 1;
   localparam int USER_W   = 2;

   // status that travels from the normalizer to the final adder
   typedef struct packed {
      logic zero;    // rotated vector is zero, no step
      logic vsign;   // v component negative
      logic usign;   // u component negative
   } nflags_type;

   localparam int NFLAGS_W = 3;

   // position of the highest set bit, zero for an all-zero word
   function automatic logic [6:0] lead_one(input logic [63:0] v);
      logic [6:0] pos;
      pos = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) pos = 7'(i);
      end
      return pos;
   endfunction

endpackage

// ----- rtl/spiral_growth_point_step_core.sv -----
// spiral_growth_point_step_core: top level of the spiral growth step
// pipeline; depends on sgps_pkg, sgps_rot, sgps_norm, sgps_sqrt, sgps_div
//
//   channel  dir  handshake            payload
//   req_     in   tvalid/tready        tdata {param, z, y, x}, tlast
//   rsp_     out  tvalid/tready        tdata {param, z, y, x}, tlast, tuser
//   csr_     in   we                   index, wdata
//
// one word per cycle in and out while the output is not stalled; the pipeline has the 31 root
// stages and the 25 divide stages plus rotate, normalize and add stages
// reset clears all valid bits and loads the register reset values
// the whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated
module spiral_growth_point_step_core #(
   parameter int COORD_WIDTH = sgps_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x, point_y, point_z, curve_param, zero fill
   input  logic [((3*COORD_WIDTH+32+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_x, next_y, next_z, next_param, zero fill
   output logic [((3*COORD_WIDTH+32+7)/8)*8-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   // degenerate, saturated
   output logic [sgps_pkg::USER_W-1:0]       rsp_tuser,
   input  logic                              csr_we,
   input  logic [sgps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgps_pkg::STEP_W-1:0]       csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int PW     = sgps_pkg::PARAM_W;
   localparam int DATA_W = ((3*CW+32+7)/8)*8;
   localparam int SW1    = 3*CW + PW + 2;
   localparam int SW4    = SW1 + sgps_pkg::NFLAGS_W;
   localparam int SW3    = SW4 + 2*sgps_pkg::NORM_W;
   localparam int DXW    = sgps_pkg::QUO_W + 1;
   localparam int SUM_W  = ((CW > DXW) ? CW : DXW) + 1;
   localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;

   logic adv;

   // configuration registers
   logic signed [sgps_pkg::ROT_COEF_W-1:0] cos_ff, sin_ff;
   logic [sgps_pkg::STEP_W-1:0]            step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff  <= sgps_pkg::ROT_COS_RST;
         sin_ff  <= sgps_pkg::ROT_SIN_RST;
         step_ff <= sgps_pkg::STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sgps_pkg::CSR_ROT_COS:  cos_ff  <= csr_wdata[sgps_pkg::ROT_COEF_W-1:0];
            sgps_pkg::CSR_ROT_SIN:  sin_ff  <= csr_wdata[sgps_pkg::ROT_COEF_W-1:0];
            sgps_pkg::CSR_STEP_LEN: step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input word unpack; side word {degen, last, param, z, y, x}
   logic [CW-1:0]  in_x, in_y, in_z;
   logic [PW-1:0]  in_param;
   logic           in_degen;
   logic [SW1-1:0] in_side;

   assign in_x     = req_tdata[CW-1:0];
   assign in_y     = req_tdata[2*CW-1:CW];
   assign in_z     = req_tdata[3*CW-1:2*CW];
   assign in_param = req_tdata[3*CW+PW-1:3*CW];
   assign in_degen = (in_x == '0) && (in_z == '0);
   assign in_side  = {in_degen, req_tlast, in_param, in_z, in_y, in_x};

   // pipeline sections
   logic                               rv_valid;
   logic signed [sgps_pkg::ROT_W-1:0]  rv_u, rv_v;
   logic [SW1-1:0]                     rv_side;

   sgps_rot #(.COORD_WIDTH(CW), .SIDE_WIDTH(SW1)) u_rot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .pt_valid (req_tvalid),
      .pt_x     (in_x),
      .pt_z     (in_z),
      .pt_side  (in_side),
      .rot_cos  (cos_ff),
      .rot_sin  (sin_ff),
      .rv_valid (rv_valid),
      .rv_u     (rv_u),
      .rv_v     (rv_v),
      .rv_side  (rv_side)
   );

   logic                               nm_valid;
   logic [sgps_pkg::NORM_W-1:0]        nm_um, nm_vm;
   logic [sgps_pkg::RAD_W-1:0]         nm_rad;
   sgps_pkg::nflags_type               nm_flags;
   logic [SW1-1:0]                     nm_side;

   sgps_norm #(.SIDE_WIDTH(SW1)) u_norm (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .rv_valid (rv_valid),
      .rv_u     (rv_u),
      .rv_v     (rv_v),
      .rv_side  (rv_side),
      .nm_valid (nm_valid),
      .nm_um    (nm_um),
      .nm_vm    (nm_vm),
      .nm_rad   (nm_rad),
      .nm_flags (nm_flags),
      .nm_side  (nm_side)
   );

   logic                               rt_valid;
   logic [sgps_pkg::ROOT_W-1:0]        rt_root;
   logic [SW3-1:0]                     rt_side;

   sgps_sqrt #(.SIDE_WIDTH(SW3)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .sq_valid (nm_valid),
      .sq_rad   (nm_rad),
      .sq_side  ({nm_vm, nm_um, nm_flags, nm_side}),
      .rt_valid (rt_valid),
      .rt_root  (rt_root),
      .rt_side  (rt_side)
   );

   logic                               qt_valid;
   logic [sgps_pkg::QUO_W-1:0]         qt_du, qt_dv;
   logic [SW4-1:0]                     qt_side;

   sgps_div #(.SIDE_WIDTH(SW4)) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .dv_valid (rt_valid),
      .dv_n     (rt_root),
      .dv_um    (rt_side[SW4 +: sgps_pkg::NORM_W]),
      .dv_vm    (rt_side[SW4+sgps_pkg::NORM_W +: sgps_pkg::NORM_W]),
      .step_len (step_ff),
      .dv_side  (rt_side[SW4-1:0]),
      .qt_valid (qt_valid),
      .qt_du    (qt_du),
      .qt_dv    (qt_dv),
      .qt_side  (qt_side)
   );

   // signed step components
   sgps_pkg::nflags_type  qt_flags;
   logic signed [DXW-1:0] dxm, dzm, dx_in, dz_in;
   logic                  f1_valid_ff;
   logic signed [DXW-1:0] dx_ff, dz_ff;
   logic [SW4-1:0]        f1_side_ff;

   assign qt_flags = sgps_pkg::nflags_type'(qt_side[SW4-1:SW1]);
   assign dxm      = {1'b0, qt_du};
   assign dzm      = {1'b0, qt_dv};
   assign dx_in    = qt_flags.usign ? -dxm : dxm;
   assign dz_in    = qt_flags.vsign ? -dzm : dzm;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= qt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff      <= dx_in;
         dz_ff      <= dz_in;
         f1_side_ff <= qt_side;
      end
   end

   // saturating add into the output register
   sgps_pkg::nflags_type   f1_flags;
   logic [CW-1:0]          f1_x, f1_y, f1_z;
   logic [PW-1:0]          f1_param;
   logic                   f1_last, f1_degen;
   logic signed [SUM_W-1:0] sx, sz;
   logic                   satx, satz;
   logic [CW-1:0]          nx_in, nz_in;
   logic                   sat_in;

   assign f1_x     = f1_side_ff[CW-1:0];
   assign f1_y     = f1_side_ff[2*CW-1:CW];
   assign f1_z     = f1_side_ff[3*CW-1:2*CW];
   assign f1_param = f1_side_ff[3*CW+PW-1:3*CW];
   assign f1_last  = f1_side_ff[3*CW+PW];
   assign f1_degen = f1_side_ff[3*CW+PW+1];
   assign f1_flags = sgps_pkg::nflags_type'(f1_side_ff[SW4-1:SW1]);

   always_comb begin
      sx   = SUM_W'($signed(f1_x)) + SUM_W'(dx_ff);
      sz   = SUM_W'($signed(f1_z)) + SUM_W'(dz_ff);
      satx = (sx > SUM_HI) || (sx < SUM_LO);
      satz = (sz > SUM_HI) || (sz < SUM_LO);
      if (f1_degen || f1_flags.zero) begin
         nx_in  = f1_x;
         nz_in  = f1_z;
         sat_in = 1'b0;
      end else begin
         nx_in  = (sx > SUM_HI) ? SUM_HI[CW-1:0] : ((sx < SUM_LO) ? SUM_LO[CW-1:0] : sx[CW-1:0]);
         nz_in  = (sz > SUM_HI) ? SUM_HI[CW-1:0] : ((sz < SUM_LO) ? SUM_LO[CW-1:0] : sz[CW-1:0]);
         sat_in = satx || satz;
      end
   end

   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [PW-1:0] rsp_param_ff;
   logic          rsp_last_ff, rsp_deg_ff, rsp_sat_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff     <= nx_in;
         rsp_y_ff     <= f1_y;
         rsp_z_ff     <= nz_in;
         rsp_param_ff <= f1_param;
         rsp_last_ff  <= f1_last;
         rsp_deg_ff   <= f1_degen;
         rsp_sat_ff   <= sat_in;
      end
   end

   // result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_param_ff, rsp_z_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;
   always_comb begin
      rsp_tuser = '0;
      rsp_tuser[sgps_pkg::USER_DEG] = rsp_deg_ff;
      rsp_tuser[sgps_pkg::USER_SAT] = rsp_sat_ff;
   end

`ifndef SYNTH
   a_deg_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_deg_ff && rsp_sat_ff))
      else $error("degenerate word flagged as saturated");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_deg_ff |-> (rsp_x_ff == '0) && (rsp_z_ff == '0))
      else $error("degenerate word has nonzero x or z");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |->
         (rsp_x_ff == SUM_HI[CW-1:0]) || (rsp_x_ff == SUM_LO[CW-1:0]) ||
         (rsp_z_ff == SUM_HI[CW-1:0]) || (rsp_z_ff == SUM_LO[CW-1:0]))
      else $error("saturated word has no coordinate at a limit");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(f1_valid_ff) && $stable(dx_ff) && $stable(dz_ff))
      else $error("add stage moved during a stall");
`endif

endmodule

// ----- rtl/sgps_rot.sv -----
// sgps_rot: prescale of (x, z) and rotation by the configured matrix,
// four register stages; depends on sgps_pkg
module sgps_rot #(
   parameter int COORD_WIDTH = sgps_pkg::COORD_WIDTH_DEF,
   parameter int SIDE_WIDTH  = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     pt_valid,
   input  logic [COORD_WIDTH-1:0]                   pt_x,
   input  logic [COORD_WIDTH-1:0]                   pt_z,
   input  logic [SIDE_WIDTH-1:0]                    pt_side,
   input  logic signed [sgps_pkg::ROT_COEF_W-1:0]   rot_cos,
   input  logic signed [sgps_pkg::ROT_COEF_W-1:0]   rot_sin,
   output logic                                     rv_valid,
   output logic signed [sgps_pkg::ROT_W-1:0]        rv_u,
   output logic signed [sgps_pkg::ROT_W-1:0]        rv_v,
   output logic [SIDE_WIDTH-1:0]                    rv_side
);

   localparam int NST = 4;

   logic [NST-1:0]          valid_ff;
   logic [SIDE_WIDTH-1:0]   side_ff [NST];

   logic [COORD_WIDTH-1:0]  xm1_ff, zm1_ff, xm1_in, zm1_in;
   logic                    xneg1_ff, zneg1_ff;
   logic signed [31:0]      xs2_ff, zs2_ff, xs2_in, zs2_in;
   logic signed [sgps_pkg::PROD_W-1:0] pcx3_ff, psz3_ff, pcz3_ff, psx3_ff;
   logic signed [sgps_pkg::ROT_W-1:0]  u4_ff, v4_ff;

   logic [6:0]              lead2;
   logic [6:0]              shamt2;
   logic [63:0]             xsh2, zsh2;
   logic signed [31:0]      xmag2, zmag2;

   // magnitudes of the inputs
   always_comb begin
      xm1_in = pt_x[COORD_WIDTH-1] ? (~pt_x + 1'b1) : pt_x;
      zm1_in = pt_z[COORD_WIDTH-1] ? (~pt_z + 1'b1) : pt_z;
   end

   // common right shift until both magnitudes fit 31 bits
   always_comb begin
      lead2  = sgps_pkg::lead_one(64'(xm1_ff | zm1_ff));
      shamt2 = (lead2 > 7'(sgps_pkg::SCALE_TOP)) ? 7'(lead2 - 7'(sgps_pkg::SCALE_TOP)) : '0;
      xsh2   = 64'(xm1_ff) >> shamt2;
      zsh2   = 64'(zm1_ff) >> shamt2;
      xmag2  = {1'b0, xsh2[sgps_pkg::SCALE_W-1:0]};
      zmag2  = {1'b0, zsh2[sgps_pkg::SCALE_W-1:0]};
      xs2_in = xneg1_ff ? -xmag2 : xmag2;
      zs2_in = zneg1_ff ? -zmag2 : zmag2;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], pt_valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= pt_side;
         for (int i = 1; i < NST; i++) side_ff[i] <= side_ff[i-1];
         xm1_ff   <= xm1_in;
         zm1_ff   <= zm1_in;
         xneg1_ff <= pt_x[COORD_WIDTH-1];
         zneg1_ff <= pt_z[COORD_WIDTH-1];
         xs2_ff   <= xs2_in;
         zs2_ff   <= zs2_in;
         pcx3_ff  <= sgps_pkg::PROD_W'(rot_cos) * sgps_pkg::PROD_W'(xs2_ff);
         psz3_ff  <= sgps_pkg::PROD_W'(rot_sin) * sgps_pkg::PROD_W'(zs2_ff);
         pcz3_ff  <= sgps_pkg::PROD_W'(rot_cos) * sgps_pkg::PROD_W'(zs2_ff);
         psx3_ff  <= sgps_pkg::PROD_W'(rot_sin) * sgps_pkg::PROD_W'(xs2_ff);
         u4_ff    <= sgps_pkg::ROT_W'(pcx3_ff) + sgps_pkg::ROT_W'(psz3_ff);
         v4_ff    <= sgps_pkg::ROT_W'(pcz3_ff) - sgps_pkg::ROT_W'(psx3_ff);
      end
   end

   assign rv_valid = valid_ff[NST-1];
   assign rv_u     = u4_ff;
   assign rv_v     = v4_ff;
   assign rv_side  = side_ff[NST-1];

endmodule

// ----- rtl/sgps_norm.sv -----
// sgps_norm: scales (|u|, |v|) so the larger lies in [2^29, 2^30) and
// forms the sum of squares, five register stages; depends on sgps_pkg
module sgps_norm #(
   parameter int SIDE_WIDTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                rv_valid,
   input  logic signed [sgps_pkg::ROT_W-1:0]   rv_u,
   input  logic signed [sgps_pkg::ROT_W-1:0]   rv_v,
   input  logic [SIDE_WIDTH-1:0]               rv_side,
   output logic                                nm_valid,
   output logic [sgps_pkg::NORM_W-1:0]         nm_um,
   output logic [sgps_pkg::NORM_W-1:0]         nm_vm,
   output logic [sgps_pkg::RAD_W-1:0]          nm_rad,
   output sgps_pkg::nflags_type                nm_flags,
   output logic [SIDE_WIDTH-1:0]               nm_side
);

   localparam int NST = 5;

   logic [NST-1:0]              valid_ff;
   logic [SIDE_WIDTH-1:0]       side_ff [NST];
   sgps_pkg::nflags_type        flags_ff [NST];
   sgps_pkg::nflags_type        flags1_in;

   logic [sgps_pkg::MAG_W-1:0]  um1_ff, vm1_ff, um1_in, vm1_in, um2_ff, vm2_ff;
   logic [6:0]                  lead2_ff;
   logic [sgps_pkg::NORM_W-1:0] um3_ff, vm3_ff, um3_in, vm3_in, um4_ff, vm4_ff, um5_ff, vm5_ff;
   logic [sgps_pkg::SQ_W-1:0]   squ4_ff, sqv4_ff;
   logic [sgps_pkg::RAD_W-1:0]  rad5_ff;
   logic [sgps_pkg::MAG_W-1:0]  ush3, vsh3;

   // magnitudes and signs
   always_comb begin
      um1_in          = rv_u[sgps_pkg::ROT_W-1] ? sgps_pkg::MAG_W'(-rv_u) : sgps_pkg::MAG_W'(rv_u);
      vm1_in          = rv_v[sgps_pkg::ROT_W-1] ? sgps_pkg::MAG_W'(-rv_v) : sgps_pkg::MAG_W'(rv_v);
      flags1_in.zero  = (rv_u == '0) && (rv_v == '0);
      flags1_in.vsign = rv_v[sgps_pkg::ROT_W-1];
      flags1_in.usign = rv_u[sgps_pkg::ROT_W-1];
   end

   // common shift that puts the leading one at bit 29
   always_comb begin
      if (lead2_ff >= 7'(sgps_pkg::NORM_TOP)) begin
         ush3 = um2_ff >> (lead2_ff - 7'(sgps_pkg::NORM_TOP));
         vsh3 = vm2_ff >> (lead2_ff - 7'(sgps_pkg::NORM_TOP));
      end else begin
         ush3 = um2_ff << (7'(sgps_pkg::NORM_TOP) - lead2_ff);
         vsh3 = vm2_ff << (7'(sgps_pkg::NORM_TOP) - lead2_ff);
      end
      um3_in = ush3[sgps_pkg::NORM_W-1:0];
      vm3_in = vsh3[sgps_pkg::NORM_W-1:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], rv_valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0]  <= rv_side;
         flags_ff[0] <= flags1_in;
         for (int i = 1; i < NST; i++) begin
            side_ff[i]  <= side_ff[i-1];
            flags_ff[i] <= flags_ff[i-1];
         end
         um1_ff   <= um1_in;
         vm1_ff   <= vm1_in;
         um2_ff   <= um1_ff;
         vm2_ff   <= vm1_ff;
         lead2_ff <= sgps_pkg::lead_one(64'(um1_ff | vm1_ff));
         um3_ff   <= um3_in;
         vm3_ff   <= vm3_in;
         squ4_ff  <= sgps_pkg::SQ_W'(um3_ff) * sgps_pkg::SQ_W'(um3_ff);
         sqv4_ff  <= sgps_pkg::SQ_W'(vm3_ff) * sgps_pkg::SQ_W'(vm3_ff);
         um4_ff   <= um3_ff;
         vm4_ff   <= vm3_ff;
         rad5_ff  <= sgps_pkg::RAD_W'(squ4_ff) + sgps_pkg::RAD_W'(sqv4_ff);
         um5_ff   <= um4_ff;
         vm5_ff   <= vm4_ff;
      end
   end

   assign nm_valid = valid_ff[NST-1];
   assign nm_um    = um5_ff;
   assign nm_vm    = vm5_ff;
   assign nm_rad   = rad5_ff;
   assign nm_flags = flags_ff[NST-1];
   assign nm_side  = side_ff[NST-1];

endmodule

// ----- rtl/sgps_sqrt.sv -----
// sgps_sqrt: integer square root, one result bit per register stage,
// 31 stages; depends on sgps_pkg
module sgps_sqrt #(
   parameter int SIDE_WIDTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           sq_valid,
   input  logic [sgps_pkg::RAD_W-1:0]     sq_rad,
   input  logic [SIDE_WIDTH-1:0]          sq_side,
   output logic                           rt_valid,
   output logic [sgps_pkg::ROOT_W-1:0]    rt_root,
   output logic [SIDE_WIDTH-1:0]          rt_side
);

   localparam int NST = sgps_pkg::ROOT_W;
   localparam int TW  = sgps_pkg::REM_W + 2;

   typedef struct packed {
      logic [sgps_pkg::REM_W-1:0]  rem;
      logic [sgps_pkg::ROOT_W-1:0] root;
      logic [sgps_pkg::RAD_W-1:0]  rest;
   } sqst_type;

   logic [NST-1:0]         valid_ff;
   logic [SIDE_WIDTH-1:0]  side_ff [NST];
   sqst_type               st_ff [NST];
   sqst_type               st_in [NST];

   // one root digit: bring down two radicand bits, try subtracting 4r+1
   function automatic sqst_type root_step(input sqst_type cur);
      sqst_type       nxt;
      logic [TW-1:0]  trial;
      logic [TW-1:0]  tsub;
      trial = {cur.rem, cur.rest[sgps_pkg::RAD_W-1 -: 2]};
      tsub  = TW'({cur.root, 2'b01});
      nxt.rest = cur.rest << 2;
      if (trial >= tsub) begin
         nxt.rem  = sgps_pkg::REM_W'(trial - tsub);
         nxt.root = {cur.root[sgps_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = sgps_pkg::REM_W'(trial);
         nxt.root = {cur.root[sgps_pkg::ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // next state of every stage
   always_comb begin
      sqst_type first;
      first.rem  = '0;
      first.root = '0;
      first.rest = sq_rad;
      st_in[0] = root_step(first);
      for (int i = 1; i < NST; i++) st_in[i] = root_step(st_ff[i-1]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], sq_valid};
      end
   end

   // root stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= sq_side;
         for (int i = 1; i < NST; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < NST; i++) st_ff[i] <= st_in[i];
      end
   end

   assign rt_valid = valid_ff[NST-1];
   assign rt_root  = st_ff[NST-1].root;
   assign rt_side  = side_ff[NST-1];

endmodule

// ----- rtl/sgps_div.sv -----
// sgps_div: step components round(step*m/n) for both axes, a multiply
// stage, a rounding stage and 25 divide stages; depends on sgps_pkg
module sgps_div #(
   parameter int SIDE_WIDTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           dv_valid,
   input  logic [sgps_pkg::ROOT_W-1:0]    dv_n,
   input  logic [sgps_pkg::NORM_W-1:0]    dv_um,
   input  logic [sgps_pkg::NORM_W-1:0]    dv_vm,
   input  logic [sgps_pkg::STEP_W-1:0]    step_len,
   input  logic [SIDE_WIDTH-1:0]          dv_side,
   output logic                           qt_valid,
   output logic [sgps_pkg::QUO_W-1:0]     qt_du,
   output logic [sgps_pkg::QUO_W-1:0]     qt_dv,
   output logic [SIDE_WIDTH-1:0]          qt_side
);

   localparam int NST  = sgps_pkg::QUO_W + 2;
   localparam int DW   = sgps_pkg::ROOT_W;
   localparam int MW   = sgps_pkg::STEP_W + sgps_pkg::NORM_W;

   typedef struct packed {
      logic [DW-1:0]              rem;
      logic [sgps_pkg::QUO_W-1:0] lo;
   } dvst_type;

   logic [NST-1:0]             valid_ff;
   logic [SIDE_WIDTH-1:0]      side_ff [NST];
   logic [DW-1:0]              n_ff [NST];

   logic [MW-1:0]              mu_ff, mv_ff;
   logic [sgps_pkg::NUM_W-1:0] numu_ff, numv_ff;
   dvst_type                   su_ff [sgps_pkg::QUO_W];
   dvst_type                   sv_ff [sgps_pkg::QUO_W];
   dvst_type                   su_in [sgps_pkg::QUO_W];
   dvst_type                   sv_in [sgps_pkg::QUO_W];

   // one quotient bit of restoring division
   function automatic dvst_type div_step(input dvst_type cur, input logic [DW-1:0] den);
      dvst_type       nxt;
      logic [DW:0]    trial;
      logic           ge;
      trial  = {cur.rem, cur.lo[sgps_pkg::QUO_W-1]};
      ge     = trial >= (DW + 1)'(den);
      nxt.rem = ge ? DW'(trial - (DW + 1)'(den)) : trial[DW-1:0];
      nxt.lo  = {cur.lo[sgps_pkg::QUO_W-2:0], ge};
      return nxt;
   endfunction

   // next state of every divide stage
   always_comb begin
      dvst_type fu, fv;
      fu.rem = DW'(numu_ff[sgps_pkg::NUM_W-1:sgps_pkg::QUO_W]);
      fu.lo  = numu_ff[sgps_pkg::QUO_W-1:0];
      fv.rem = DW'(numv_ff[sgps_pkg::NUM_W-1:sgps_pkg::QUO_W]);
      fv.lo  = numv_ff[sgps_pkg::QUO_W-1:0];
      su_in[0] = div_step(fu, n_ff[1]);
      sv_in[0] = div_step(fv, n_ff[1]);
      for (int i = 1; i < sgps_pkg::QUO_W; i++) begin
         su_in[i] = div_step(su_ff[i-1], n_ff[i+1]);
         sv_in[i] = div_step(sv_ff[i-1], n_ff[i+1]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], dv_valid};
      end
   end

   // multiply, round and divide stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= dv_side;
         n_ff[0]    <= dv_n;
         for (int i = 1; i < NST; i++) begin
            side_ff[i] <= side_ff[i-1];
            n_ff[i]    <= n_ff[i-1];
         end
         mu_ff   <= MW'(step_len) * MW'(dv_um);
         mv_ff   <= MW'(step_len) * MW'(dv_vm);
         numu_ff <= sgps_pkg::NUM_W'(mu_ff) + sgps_pkg::NUM_W'(n_ff[0] >> 1);
         numv_ff <= sgps_pkg::NUM_W'(mv_ff) + sgps_pkg::NUM_W'(n_ff[0] >> 1);
         for (int i = 0; i < sgps_pkg::QUO_W; i++) begin
            su_ff[i] <= su_in[i];
            sv_ff[i] <= sv_in[i];
         end
      end
   end

   assign qt_valid = valid_ff[NST-1];
   assign qt_du    = su_ff[sgps_pkg::QUO_W-1].lo;
   assign qt_dv    = sv_ff[sgps_pkg::QUO_W-1].lo;
   assign qt_side  = side_ff[NST-1];

endmodule

// ----- verif/tb_spiral_growth_point_step_core.sv -----
// tb_spiral_growth_point_step_core: self-checking bench for the spiral growth step core
// drives points on req_, checks rsp_ against a local fixed-point growth predictor;
// depends on sgps_pkg and spiral_growth_point_step_core
`timescale 1ns / 1ps

module tb_spiral_growth_point_step_core;

   localparam int DATA_W = 128;
   localparam int LIMIT_CYCLES = 600000;
   localparam int PIPE_DRAIN = 90;
   // index with no register behind it
   localparam logic [sgps_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [31:0] x, y, z, param;
      bit          last, degen, sat;
   } grown_point_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [DATA_W-1:0]              req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [DATA_W-1:0]              rsp_tdata;
   logic                           rsp_tlast;
   logic [sgps_pkg::USER_W-1:0]    rsp_tuser;
   logic                           csr_we = 1'b0;
   logic [sgps_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sgps_pkg::STEP_W-1:0]    csr_wdata = '0;

   // local copy of the registers
   logic [sgps_pkg::ROT_COEF_W-1:0] cos_reg  = sgps_pkg::ROT_COS_RST;
   logic [sgps_pkg::ROT_COEF_W-1:0] sin_reg  = sgps_pkg::ROT_SIN_RST;
   logic [sgps_pkg::STEP_W-1:0]     step_reg = sgps_pkg::STEP_RST;

   grown_point_type pending_points[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  no_gaps = 1'b0;

   spiral_growth_point_step_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic longint unsigned floor_root(input longint unsigned a);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > a) b >>= 2;
      while (b != 0) begin
         if (a >= r + b) begin
            a -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // clamp a coordinate sum to 32 bits signed
   function automatic longint clamp_coord(input longint s, inout bit sat);
      if (s > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (s < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return s;
   endfunction

   // one growth step on the current registers
   function automatic grown_point_type grow_point(input logic [31:0] px, py, pz, pp,
                                                  input bit last);
      grown_point_type r;
      longint          x, z, xs, zs, c, s, u, v, dx, dz;
      longint unsigned xm, zm, um, vm, n, dxm, dzm;
      int              k;
      x = longint'($signed(px));
      z = longint'($signed(pz));
      r.x = px; r.y = py; r.z = pz; r.param = pp; r.last = last;
      r.degen = 1'b0; r.sat = 1'b0;
      if (x == 0 && z == 0) begin
         r.degen = 1'b1;
         return r;
      end
      xm = x < 0 ? -x : x;
      zm = z < 0 ? -z : z;
      k = 0;
      while (((xm | zm) >> k) >= (64'd1 << 31)) k++;
      xs = longint'(xm >> k);
      zs = longint'(zm >> k);
      if (x < 0) xs = -xs;
      if (z < 0) zs = -zs;
      c = longint'($signed(cos_reg));
      s = longint'($signed(sin_reg));
      u = c * xs + s * zs;
      v = -s * xs + c * zs;
      um = u < 0 ? -u : u;
      vm = v < 0 ? -v : v;
      if (um == 0 && vm == 0) return r;
      while ((um | vm) >= (64'd1 << 30)) begin
         um >>= 1;
         vm >>= 1;
      end
      while ((um | vm) < (64'd1 << 29)) begin
         um <<= 1;
         vm <<= 1;
      end
      n = floor_root(um * um + vm * vm);
      dxm = (longint'(step_reg) * um + (n >> 1)) / n;
      dzm = (longint'(step_reg) * vm + (n >> 1)) / n;
      dx = u < 0 ? -longint'(dxm) : longint'(dxm);
      dz = v < 0 ? -longint'(dzm) : longint'(dzm);
      r.x = 32'(clamp_coord(x + dx, r.sat));
      r.z = 32'(clamp_coord(z + dz, r.sat));
      return r;
   endfunction

   // offer one word after a random gap; valid stays high across back-to-back words
   task automatic send_point(input logic [31:0] px, py, pz, pp, input bit last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pp, pz, py, px};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pending_points.insert(pending_points.size(), grow_point(px, py, pz, pp, last));
   endtask

   // stop sending and wait for every result
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sgps_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sgps_pkg::STEP_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      unique case (idx)
         sgps_pkg::CSR_ROT_COS:  cos_reg  = val[sgps_pkg::ROT_COEF_W-1:0];
         sgps_pkg::CSR_ROT_SIN:  sin_reg  = val[sgps_pkg::ROT_COEF_W-1:0];
         sgps_pkg::CSR_STEP_LEN: step_reg = val;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return 32'($signed($urandom_range(0, 2000)) - 1000);
         4: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [31:0] x, z;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         x = rand_coord();
         z = rand_coord();
         if ($urandom_range(0, 30) == 0) begin
            x = '0;
            z = '0;
         end
         send_point(x, $urandom, z, $urandom, $urandom_range(0, 1));
      end
      no_gaps = 1'b0;
   endtask

   // result side: random stall per word, then compare with the oldest expectation
   initial begin : check_results
      int              stall;
      grown_point_type want, got;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid || reset);
         {got.param, got.z, got.y, got.x} = rsp_tdata;
         got.last  = rsp_tlast;
         got.degen = rsp_tuser[sgps_pkg::USER_DEG];
         got.sat   = rsp_tuser[sgps_pkg::USER_SAT];
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word: x=%h z=%h", got.x, got.z);
         end else begin
            want = pending_points.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp x=%h y=%h z=%h p=%h l=%b d=%b s=%b",
                           want.x, want.y, want.z, want.param, want.last, want.degen,
                           want.sat);
                  $display("          got x=%h y=%h z=%h p=%h l=%b d=%b s=%b",
                           got.x, got.y, got.z, got.param, got.last, got.degen, got.sat);
               end
            end
         end
      end
   end

   // field extremes, zero point, axis points, both tlast values
   task automatic test_directed();
      send_point(32'h0, 32'h1234_5678, 32'h0, 32'hdead_beef, 1'b1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      send_point(32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 1'b0);
      send_point(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'hffff_ffff, 1'b1);
      send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);
      send_point(32'h0, 32'h0, 32'hffff_0000, 32'h0, 1'b0);
      send_point(32'h1, 32'h5555_5555, 32'h0, 32'haaaa_aaaa, 1'b1);
      send_point(32'h7fff_fff0, 32'h0, 32'h7fff_fff0, 32'h0, 1'b0);
      send_point(32'h8000_0010, 32'h0, 32'h8000_0010, 32'h0, 1'b1);
      settle();
   endtask

   // rotated vector is zero, a nonzero point passes with no flags; the zero point is degenerate
   task automatic test_zero_matrix();
      write_reg(sgps_pkg::CSR_ROT_COS, '0);
      write_reg(sgps_pkg::CSR_ROT_SIN, '0);
      send_point(32'h0002_0000, 32'h1, 32'h0003_0000, 32'h2, 1'b1);
      send_point(32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'h2, 1'b0);
      send_point(32'h0, 32'h1, 32'h0, 32'h2, 1'b0);
      settle();
   endtask

   // full 18-bit coefficients, largest and zero step, junk above the register width
   task automatic test_register_extremes();
      write_reg(sgps_pkg::CSR_ROT_COS, 24'hfe0000);
      write_reg(sgps_pkg::CSR_ROT_SIN, 24'h01ffff);
      write_reg(sgps_pkg::CSR_STEP_LEN, 24'hffffff);
      send_random(12);
      settle();
      write_reg(sgps_pkg::CSR_ROT_COS, 24'(18'sd65536));
      write_reg(sgps_pkg::CSR_ROT_SIN, 24'(-18'sd65536));
      write_reg(sgps_pkg::CSR_STEP_LEN, '0);
      send_random(6);
      settle();
   endtask

   // writes to the unused index leave the registers alone
   task automatic test_spare_index();
      write_reg(CSR_SPARE, 24'hffffff);
      write_reg(CSR_SPARE, 24'h000000);
      send_random(6);
      settle();
   endtask

   // random points over several register settings
   task automatic test_random_sweep();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(sgps_pkg::CSR_ROT_COS, 24'($urandom));
         write_reg(sgps_pkg::CSR_ROT_SIN, 24'($urandom));
         write_reg(sgps_pkg::CSR_STEP_LEN,
                   phase == 0 ? 24'hffffff : 24'($urandom_range(0, 24'h0fffff)));
         send_random(230);
         settle();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_zero_matrix();
      test_register_extremes();
      test_spare_index();
      test_random_sweep();
      if (mismatch_count == 0 && pending_points.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
